// File: design/wrg_pkg.sv
// ----------------------------------------------------------------------------
// wrg_pkg
// Shared types, constants and helpers for the wrist raise gesture detector.
// ----------------------------------------------------------------------------
package wrg_pkg;

    // axis phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ARMED  = 2'd1;
    localparam logic [1:0] PH_FALLEN = 2'd2;

    // declines counted, the first one included, that make an axis fallen; a broken run keeps its count
    localparam logic [7:0] FALL_RUN_Y = 8'd3;
    localparam logic [7:0] FALL_RUN_X = 8'd3;

    // configuration register indexes
    localparam logic [2:0] REG_START_THR_Y  = 3'd0;
    localparam logic [2:0] REG_PEAK_THR_Y   = 3'd1;
    localparam logic [2:0] REG_START_THR_X  = 3'd2;
    localparam logic [2:0] REG_PEAK_THR_X   = 3'd3;
    localparam logic [2:0] REG_VIEW_LIMIT_X = 3'd4;
    localparam logic [2:0] REG_VIEW_LIMIT_Y = 3'd5;
    localparam logic [2:0] REG_WAIT_LIMIT   = 3'd6;
    localparam logic [2:0] REG_HOLD_LIMIT   = 3'd7;

    // configuration reset values
    localparam logic [14:0] START_THR_Y_RST  = 15'd3000;
    localparam logic [14:0] PEAK_THR_Y_RST   = 15'd6000;
    localparam logic [15:0] START_THR_X_RST  = 16'd4000;
    localparam logic [15:0] PEAK_THR_X_RST   = 16'd8000;
    localparam logic [15:0] VIEW_LIMIT_X_RST = 16'd6000;
    localparam logic [15:0] VIEW_LIMIT_Y_RST = 16'd2000;
    localparam logic [7:0]  WAIT_LIMIT_RST   = 8'd3;
    localparam logic [7:0]  HOLD_LIMIT_RST   = 8'd4;

    // per-axis update result
    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] count;
        logic       fell;
    } axis_upd_t;

    // viewing-angle controller result
    typedef struct packed {
        logic [7:0] hold_cnt;
        logic [7:0] wait_cnt;
        logic       clear;
        logic       raise;
    } view_upd_t;

    // magnitude of a 16 bit sample, -32768 gives 32768
    function automatic logic signed [16:0] abs17(input logic [15:0] v);
        logic signed [16:0] ext;
        begin
            ext = $signed({v[15], v});
            abs17 = v[15] ? -ext : ext;
        end
    endfunction

endpackage

// File: design/wrg_axis.sv
// ----------------------------------------------------------------------------
// wrg_axis
// One axis phase update: arm above start, check the peak at the first
// decline, count declines until the axis has fallen.
// ----------------------------------------------------------------------------
module wrg_axis
(
    input  logic [1:0]         phase,
    input  logic [7:0]         count,
    input  logic signed [16:0] cur,
    input  logic signed [16:0] old,
    input  logic signed [16:0] start_thr,
    input  logic signed [16:0] peak_thr,
    input  logic [7:0]         run,
    output wrg_pkg::axis_upd_t upd
);

    logic [1:0] phase_arm;
    logic [7:0] count_inc;

    // arm from idle
    assign phase_arm = ((phase == wrg_pkg::PH_IDLE) && (cur > start_thr))
                       ? wrg_pkg::PH_ARMED : phase;
    assign count_inc = count + 8'd1;

    // decline tracking while armed
    always_comb
    begin
        upd.phase = phase_arm;
        upd.count = count;
        upd.fell  = 1'b0;
        if (phase_arm == wrg_pkg::PH_ARMED)
        begin
            if (cur < old)
            begin
                upd.count = count_inc;
                if (count_inc == 8'd1)
                begin
                    // first decline must start at or above the peak
                    if (old < peak_thr)
                    begin
                        upd.count = 8'd0;
                        upd.phase = wrg_pkg::PH_IDLE;
                    end
                end
                else if (count_inc >= run)
                begin
                    upd.phase = wrg_pkg::PH_FALLEN;
                    upd.count = 8'd0;
                    upd.fell  = 1'b1;
                end
            end
            else
            begin
                // run broken, count is kept
                upd.phase = (cur > start_thr) ? wrg_pkg::PH_ARMED : wrg_pkg::PH_IDLE;
            end
        end
    end

endmodule

// File: design/wrg_view.sv
// ----------------------------------------------------------------------------
// wrg_view
// Viewing-angle controller: after a fall, counts samples held at the
// viewing angle and reports a raise, or clears on timeout or a broken hold.
// ----------------------------------------------------------------------------
module wrg_view
(
    input  logic                fallen,
    input  logic signed [16:0]  ax,
    input  logic signed [16:0]  y,
    input  logic signed [16:0]  view_limit_x,
    input  logic signed [16:0]  view_limit_y,
    input  logic [7:0]          wait_limit,
    input  logic [7:0]          hold_limit,
    input  logic [7:0]          hold_cnt,
    input  logic [7:0]          wait_cnt,
    output wrg_pkg::view_upd_t  upd
);

    logic       in_view;
    logic [7:0] hold_inc;
    logic [7:0] wait_inc;

    assign in_view  = (ax <= view_limit_x) && (y <= view_limit_y);
    assign hold_inc = hold_cnt + 8'd1;
    assign wait_inc = wait_cnt + 8'd1;

    // hold / timeout decision
    always_comb
    begin
        upd.hold_cnt = hold_cnt;
        upd.wait_cnt = wait_cnt;
        upd.clear    = 1'b0;
        upd.raise    = 1'b0;
        if (fallen)
        begin
            if (in_view)
            begin
                upd.hold_cnt = hold_inc;
                if (hold_inc >= hold_limit)
                begin
                    upd.hold_cnt = 8'd0;
                    upd.wait_cnt = 8'd0;
                    upd.clear    = 1'b1;
                    upd.raise    = 1'b1;
                end
            end
            else if (hold_cnt == 8'd0)
            begin
                upd.wait_cnt = wait_inc;
                if (wait_inc >= wait_limit)
                begin
                    upd.wait_cnt = 8'd0;
                    upd.clear    = 1'b1;
                end
            end
            else
            begin
                // angle broke during the hold
                upd.hold_cnt = 8'd0;
                upd.wait_cnt = 8'd0;
                upd.clear    = 1'b1;
            end
        end
    end

endmodule

// File: design/wrist_raise_gesture_detector_top.sv
// ----------------------------------------------------------------------------
// wrist_raise_gesture_detector_top
// Wrist raise detection on a stream of X/Y accelerometer samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one sample per item (acc_x, acc_y); m_* channel gives
//   one result per sample (raise_detected, fast_rate).
//   Configuration is written through cfg_we/cfg_addr/cfg_data while the
//   block is idle; writes take effect at the next clock edge.
// Pipeline and throughput:
//   an accepted item is held in the input register, then the axis
//   and viewing-angle logic updates the state and loads the result register,
//   from which the result is offered on the m_* channel.
//   One item per cycle is sustained while m_tready does not stall the result.
// Reset:
//   rst_n clears both stages, all axis phases and counters, the previous
//   sample, and returns the configuration registers to their defaults.
// Stall:
//   while m_tready is low and a result waits, the input register still takes
//   one item; after that s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module wrist_raise_gesture_detector_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] acc_x, [31:16] acc_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] raise_detected, [1] fast_rate, [7:2] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [14:0] start_thr_y_reg;
    logic [14:0] peak_thr_y_reg;
    logic [15:0] start_thr_x_reg;
    logic [15:0] peak_thr_x_reg;
    logic [15:0] view_limit_x_reg;
    logic [15:0] view_limit_y_reg;
    logic [7:0]  wait_limit_reg;
    logic [7:0]  hold_limit_reg;

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [15:0] in_x_reg;
    logic [15:0] in_y_reg;

    // detector state
    logic [15:0] prev_x_reg;
    logic [15:0] prev_y_reg;
    logic [1:0]  phase_y_reg, phase_y_next;
    logic [1:0]  phase_x_reg, phase_x_next;
    logic [7:0]  decl_y_reg;
    logic [7:0]  decl_x_reg;
    logic [7:0]  wait_cnt_reg;
    logic [7:0]  hold_cnt_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic        out_raise_reg;
    logic        out_fast_reg;

    logic        s_accept;
    logic        advance;

    logic signed [16:0] cur_ax;
    logic signed [16:0] old_ax;
    logic signed [16:0] cur_y;
    logic signed [16:0] old_y;
    logic [7:0]         wait_in;
    logic               fallen;

    wrg_pkg::axis_upd_t upd_y;
    wrg_pkg::axis_upd_t upd_x;
    wrg_pkg::view_upd_t upd_v;

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_fast_reg, out_raise_reg};

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // compare forms
    assign cur_ax = wrg_pkg::abs17(in_x_reg);
    assign old_ax = wrg_pkg::abs17(prev_x_reg);
    assign cur_y  = $signed({in_y_reg[15], in_y_reg});
    assign old_y  = $signed({prev_y_reg[15], prev_y_reg});

    // axis updates
    wrg_axis u_axis_y
    (
        .phase     (phase_y_reg),
        .count     (decl_y_reg),
        .cur       (cur_y),
        .old       (old_y),
        .start_thr ($signed({2'b00, start_thr_y_reg})),
        .peak_thr  ($signed({2'b00, peak_thr_y_reg})),
        .run       (wrg_pkg::FALL_RUN_Y),
        .upd       (upd_y)
    );

    wrg_axis u_axis_x
    (
        .phase     (phase_x_reg),
        .count     (decl_x_reg),
        .cur       (cur_ax),
        .old       (old_ax),
        .start_thr ($signed({1'b0, start_thr_x_reg})),
        .peak_thr  ($signed({1'b0, peak_thr_x_reg})),
        .run       (wrg_pkg::FALL_RUN_X),
        .upd       (upd_x)
    );

    // a fresh fall restarts the wait
    assign wait_in = (upd_y.fell || upd_x.fell) ? 8'd0 : wait_cnt_reg;
    assign fallen  = (upd_y.phase >= wrg_pkg::PH_FALLEN) ||
                     (upd_x.phase >= wrg_pkg::PH_FALLEN);

    wrg_view u_view
    (
        .fallen       (fallen),
        .ax           (cur_ax),
        .y            (cur_y),
        .view_limit_x ($signed({1'b0, view_limit_x_reg})),
        .view_limit_y ($signed({view_limit_y_reg[15], view_limit_y_reg})),
        .wait_limit   (wait_limit_reg),
        .hold_limit   (hold_limit_reg),
        .hold_cnt     (hold_cnt_reg),
        .wait_cnt     (wait_in),
        .upd          (upd_v)
    );

    assign phase_y_next = upd_v.clear ? wrg_pkg::PH_IDLE : upd_y.phase;
    assign phase_x_next = upd_v.clear ? wrg_pkg::PH_IDLE : upd_x.phase;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_thr_y_reg  <= wrg_pkg::START_THR_Y_RST;
            peak_thr_y_reg   <= wrg_pkg::PEAK_THR_Y_RST;
            start_thr_x_reg  <= wrg_pkg::START_THR_X_RST;
            peak_thr_x_reg   <= wrg_pkg::PEAK_THR_X_RST;
            view_limit_x_reg <= wrg_pkg::VIEW_LIMIT_X_RST;
            view_limit_y_reg <= wrg_pkg::VIEW_LIMIT_Y_RST;
            wait_limit_reg   <= wrg_pkg::WAIT_LIMIT_RST;
            hold_limit_reg   <= wrg_pkg::HOLD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wrg_pkg::REG_START_THR_Y:  start_thr_y_reg  <= cfg_data[14:0];
                wrg_pkg::REG_PEAK_THR_Y:   peak_thr_y_reg   <= cfg_data[14:0];
                wrg_pkg::REG_START_THR_X:  start_thr_x_reg  <= cfg_data;
                wrg_pkg::REG_PEAK_THR_X:   peak_thr_x_reg   <= cfg_data;
                wrg_pkg::REG_VIEW_LIMIT_X: view_limit_x_reg <= cfg_data;
                wrg_pkg::REG_VIEW_LIMIT_Y: view_limit_y_reg <= cfg_data;
                wrg_pkg::REG_WAIT_LIMIT:   wait_limit_reg   <= cfg_data[7:0];
                wrg_pkg::REG_HOLD_LIMIT:   hold_limit_reg   <= cfg_data[7:0];
                default:                   hold_limit_reg   <= hold_limit_reg;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_x_reg <= s_tdata[15:0];
            in_y_reg <= s_tdata[31:16];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_raise_reg <= upd_v.raise;
            out_fast_reg  <= (phase_y_next != wrg_pkg::PH_IDLE) ||
                             (phase_x_next != wrg_pkg::PH_IDLE);
        end
    end

    // detector state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg   <= 16'd0;
            prev_y_reg   <= 16'd0;
            phase_y_reg  <= wrg_pkg::PH_IDLE;
            phase_x_reg  <= wrg_pkg::PH_IDLE;
            decl_y_reg   <= 8'd0;
            decl_x_reg   <= 8'd0;
            wait_cnt_reg <= 8'd0;
            hold_cnt_reg <= 8'd0;
        end
        else if (advance)
        begin
            prev_x_reg   <= in_x_reg;
            prev_y_reg   <= in_y_reg;
            phase_y_reg  <= phase_y_next;
            phase_x_reg  <= phase_x_next;
            decl_y_reg   <= upd_y.count;
            decl_x_reg   <= upd_x.count;
            wait_cnt_reg <= upd_v.wait_cnt;
            hold_cnt_reg <= upd_v.hold_cnt;
        end
    end

`ifndef SYNTHESIS
    // a raise returns both axes to idle, so fast rate is off with it
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[1])
        else $error("raise reported with an axis still active");

    // a running hold only exists while an axis has fallen
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_cnt_reg != 8'd0) |->
        ((phase_y_reg == wrg_pkg::PH_FALLEN) || (phase_x_reg == wrg_pkg::PH_FALLEN)))
        else $error("hold count set with no fallen axis");

    // a new result only comes from a held input item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result appeared without an input item");
`endif

endmodule
